FILE: rtl/srcs_pkg.sv
// Shared types, constants and a helper function of the selective-repeat chunk scheduler.
`default_nettype none

package srcs_pkg;

  localparam int MAX_CHUNKS = 1024;
  localparam int WORD_BITS  = 32;
  localparam int NWORDS     = MAX_CHUNKS / WORD_BITS;
  localparam int WIDX_W     = $clog2(NWORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CHUNK_W    = WIDX_W + BIT_W;
  localparam int CNT_W      = CHUNK_W + 1;
  localparam int NWC_W      = WIDX_W + 1;
  localparam int IMG_W      = 32;
  localparam int TOT_W      = 11;
  localparam int CTR_W      = 16;

  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] MAX_CHUNKS_C = CNT_W'(MAX_CHUNKS);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_NUMBER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_TOTAL  = 1'b1;

  typedef enum logic [1:0] {
    OP_ACK_WORD = 2'd0,
    OP_BUILD    = 2'd1,
    OP_NEXT     = 2'd2,
    OP_RESTART  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_WRONG_IMAGE    = 2'd1,
    ST_COUNT_MISMATCH = 2'd2,
    ST_NOTHING        = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RESEND_RD,
    BK_SCAN_LOAD,
    BK_SCAN_PICK
  } bk_state_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_t                 op;
    logic [WIDX_W-1:0]   widx;
    logic [WORD_BITS-1:0] word;
    logic                last;
    logic                commit;
    logic                set_done;
    status_t             ack_status;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    status_t             status;
    logic [CHUNK_W-1:0]  chunk_id;
    logic                is_resend;
    logic                is_last_chunk;
    logic                all_done;
    logic [CNT_W-1:0]    resend_pending;
    logic [CTR_W-1:0]    sent_total;
    logic [CTR_W-1:0]    ack_total;
  } res_t;

  // Position of the lowest set bit; the lowest bit is isolated first so the
  // encoding is a plain OR over independent positions.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] one;
    logic [BIT_W-1:0]     idx;
    one = v & (~v + 1'b1);
    idx = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (one[k]) idx = idx | BIT_W'(k);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/selective_repeat_chunk_scheduler.sv
// With the back end free, an accepted transaction is queued by the front end and its result is
// registered when the back end takes it; a resending NEXT first reads the RAM in BK_RESEND_RD.
// BUILD holds the back end while it loads each word with sent chunks and lists each entry found.
// Throughput: one transaction per cycle, set by the back end, unless results stall, NEXT resends or BUILD scans.
// Reset: synchronous active-low; clears maps, counters, queue and registers (image 0,
// chunk total 1); the resend-list RAM is not cleared and needs no clearing pass.
`default_nettype none

module selective_repeat_chunk_scheduler import srcs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // word_index[4:0], bitmap_word[36:5], ack_image[68:37], ack_chunk_total[79:69],
  // rcv_count[90:80], ack_complete[91], zero padding [95:92]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic                  in_tlast,
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // chunk_id[9:0], all_done[10], resend_pending[21:11], sent_total[37:22],
  // ack_total[53:38], zero padding [55:54]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status[1:0], is_resend[2]
  output logic [OUT_USER_W-1:0]      out_tuser,
  output logic                       out_tlast,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers. They are to be written by the user only while the block is idle,
  // which the block does not enforce, so that both halves of the pipeline may read them directly.
  logic [IMG_W-1:0] image_number_r, image_number_nxt;
  logic [TOT_W-1:0] chunk_total_r, chunk_total_nxt;

  always_comb begin
    image_number_nxt = image_number_r;
    chunk_total_nxt  = chunk_total_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_NUMBER: image_number_nxt = cfg_wdata[IMG_W-1:0];
        CFG_CHUNK_TOTAL:  chunk_total_nxt  = cfg_wdata[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_number_r <= '0;
      chunk_total_r  <= TOT_W'(1);
    end else begin
      image_number_r <= image_number_nxt;
      chunk_total_r  <= chunk_total_nxt;
    end
  end

  // The front end judges each transaction and queues it; the back end works
  // through the queue one command at a time and owns the result register,
  // so a stalled result never blocks the input side until the queue fills.
  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  srcs_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_tvalid),
    .in_ready           (in_tready),
    .in_func            (in_tuser),
    .in_word_index      (in_tdata[4:0]),
    .in_bitmap_word     (in_tdata[36:5]),
    .in_ack_last        (in_tlast),
    .in_ack_image       (in_tdata[68:37]),
    .in_ack_chunk_total (in_tdata[79:69]),
    .in_rcv_count       (in_tdata[90:80]),
    .in_ack_complete    (in_tdata[91]),
    .image_number       (image_number_r),
    .chunk_total        (chunk_total_r),
    .cmd_valid          (cmd_valid),
    .cmd_ready          (cmd_ready),
    .cmd                (cmd)
  );

  srcs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .chunk_total (chunk_total_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .res         (res)
  );

  // Pack the result transaction onto the stream.
  assign out_tdata = {2'b00, res.ack_total, res.sent_total, res.resend_pending,
                      res.all_done, res.chunk_id};
  assign out_tuser = {res.is_resend, res.status};
  assign out_tlast = res.is_last_chunk;

endmodule

`default_nettype wire

FILE: rtl/srcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module srcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/srcs_front.sv
// Front end: accepts input transactions, checks ACK headers and queues commands.
`default_nettype none

module srcs_front import srcs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_func,
  input  wire logic [WIDX_W-1:0]    in_word_index,
  input  wire logic [WORD_BITS-1:0] in_bitmap_word,
  input  wire logic                 in_ack_last,
  input  wire logic [IMG_W-1:0]     in_ack_image,
  input  wire logic [TOT_W-1:0]     in_ack_chunk_total,
  input  wire logic [TOT_W-1:0]     in_rcv_count,
  input  wire logic                 in_ack_complete,
  input  wire logic [IMG_W-1:0]     image_number,
  input  wire logic [TOT_W-1:0]     chunk_total,
  output logic                      cmd_valid,
  input  wire logic                 cmd_ready,
  output cmd_t                      cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;
  logic       img_bad, tot_bad;
  cmd_t       cls;

  // The user must change the registers only with nothing in flight (not enforced),
  // so the header can be judged here against the values the back end will also see.
  always_comb begin
    img_bad      = in_ack_image != image_number;
    tot_bad      = in_ack_chunk_total != chunk_total;
    cls.op       = op_t'(in_func);
    cls.widx     = in_word_index;
    cls.word     = in_bitmap_word;
    cls.last     = in_ack_last;
    cls.commit   = in_ack_last && !img_bad && !tot_bad;
    cls.set_done = in_ack_last && !img_bad && !tot_bad &&
                   (in_ack_complete || (in_rcv_count == chunk_total));
    if (!in_ack_last)  cls.ack_status = ST_OK;
    else if (img_bad)  cls.ack_status = ST_WRONG_IMAGE;
    else if (tot_bad)  cls.ack_status = ST_COUNT_MISMATCH;
    else               cls.ack_status = ST_OK;
  end

  always_comb begin
    in_ready   = fill_r != 2'd2;
    cmd_valid  = fill_r != 2'd0;
    cmd        = q_r[rd_ptr_r];
    push       = in_valid && in_ready;
    pop        = cmd_valid && cmd_ready;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end

endmodule

`default_nettype wire

FILE: rtl/srcs_back.sv
// Back end: executes queued commands against the maps, counters and resend list.
`default_nettype none

module srcs_back import srcs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire cmd_t             cmd,
  input  wire logic [TOT_W-1:0] chunk_total,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output res_t                  res
);

  bk_state_t state_r, state_nxt;

  logic [WORD_BITS-1:0] acked_r  [NWORDS];
  logic [WORD_BITS-1:0] acked_nxt [NWORDS];
  logic [WORD_BITS-1:0] shadow_r [NWORDS];
  logic [WORD_BITS-1:0] shadow_nxt [NWORDS];

  logic [CNT_W-1:0]     rcount_r, rcount_nxt;
  logic [CNT_W-1:0]     rpos_r, rpos_nxt;
  logic [CNT_W-1:0]     next_new_r, next_new_nxt;
  logic                 done_r, done_nxt;
  logic [CTR_W-1:0]     sent_r, sent_nxt;
  logic [CTR_W-1:0]     ackc_r, ackc_nxt;
  logic [NWC_W-1:0]     wc_r, wc_nxt;
  logic [NWC_W-1:0]     nwords_r, nwords_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [WORD_BITS-1:0] mask_r, mask_nxt;
  logic [WIDX_W-1:0]    mbase_r, mbase_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 res_r, res_nxt;

  logic                 slot_free, take;
  logic [CNT_W-1:0]     eff_total, limit_c, lim_round;
  logic [WORD_BITS-1:0] lim_mask;
  logic [BIT_W-1:0]     pick_bit;

  logic                 ram_we;
  logic [CHUNK_W-1:0]   ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  function automatic logic last_of(input logic [CHUNK_W-1:0] c,
                                   input logic [TOT_W-1:0]   tot);
    return (tot != '0) && (TOT_W'(c) == tot - TOT_W'(1));
  endfunction

  srcs_ram #(
    .WIDTH (CHUNK_W),
    .DEPTH (MAX_CHUNKS)
  ) u_resend_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    slot_free = !out_valid_r || out_ready;
    cmd_ready = (state_r == BK_IDLE) && slot_free;
    take      = cmd_valid && cmd_ready;
    eff_total = (TOT_W'(chunk_total) > MAX_CHUNKS_C) ? MAX_CHUNKS_C : chunk_total;
    // Chunks issued as new are exactly those below next_new.
    limit_c   = (next_new_r < eff_total) ? next_new_r : eff_total;
    lim_round = limit_c + CNT_W'(WORD_BITS - 1);
    for (int k = 0; k < WORD_BITS; k++) begin
      lim_mask[k] = CNT_W'({wc_r[WIDX_W-1:0], BIT_W'(k)}) < limit_r;
    end
    pick_bit  = lowest_set(mask_r);
    out_valid = out_valid_r;
    res       = res_r;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (take && cmd.op == OP_BUILD) begin
          state_nxt = BK_SCAN_LOAD;
        end else if (take && cmd.op == OP_NEXT && !done_r && rpos_r < rcount_r) begin
          state_nxt = BK_RESEND_RD;
        end
      end
      BK_RESEND_RD: state_nxt = BK_IDLE;
      BK_SCAN_LOAD: begin
        state_nxt = (wc_r == nwords_r) ? BK_IDLE : BK_SCAN_PICK;
      end
      BK_SCAN_PICK: begin
        if (mask_r == '0) state_nxt = BK_SCAN_LOAD;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and result logic.
  always_comb begin
    acked_nxt     = acked_r;
    shadow_nxt    = shadow_r;
    rcount_nxt    = rcount_r;
    rpos_nxt      = rpos_r;
    next_new_nxt  = next_new_r;
    done_nxt      = done_r;
    sent_nxt      = sent_r;
    ackc_nxt      = ackc_r;
    wc_nxt        = wc_r;
    nwords_nxt    = nwords_r;
    limit_nxt     = limit_r;
    mask_nxt      = mask_r;
    mbase_nxt     = mbase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = rcount_r[CHUNK_W-1:0];
    ram_wdata     = {mbase_r, pick_bit};
    ram_raddr     = rpos_r[CHUNK_W-1:0];

    unique case (state_r)
      BK_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_ACK_WORD: begin
              if (!cmd.last) begin
                shadow_nxt[cmd.widx] = cmd.word;
              end else begin
                if (cmd.commit) begin
                  for (int j = 0; j < NWORDS; j++) begin
                    acked_nxt[j] = (WIDX_W'(j) == cmd.widx) ? cmd.word : shadow_r[j];
                  end
                  ackc_nxt = ackc_r + CTR_W'(1);
                  done_nxt = done_r || cmd.set_done;
                end
                for (int j = 0; j < NWORDS; j++) shadow_nxt[j] = '0;
              end
            end
            OP_BUILD: begin
              rcount_nxt = '0;
              rpos_nxt   = '0;
              limit_nxt  = limit_c;
              nwords_nxt = lim_round[CNT_W-1:BIT_W];
              wc_nxt     = '0;
            end
            OP_NEXT: begin
              if (!done_r && rpos_r < rcount_r) begin
                rpos_nxt = rpos_r + CNT_W'(1);
                sent_nxt = sent_r + CTR_W'(1);
              end else if (!done_r && next_new_r < eff_total) begin
                next_new_nxt = next_new_r + CNT_W'(1);
                sent_nxt     = sent_r + CTR_W'(1);
              end
            end
            default: begin
              for (int j = 0; j < NWORDS; j++) begin
                acked_nxt[j]  = '0;
                shadow_nxt[j] = '0;
              end
              rcount_nxt   = '0;
              rpos_nxt     = '0;
              next_new_nxt = '0;
              done_nxt     = 1'b0;
              sent_nxt     = '0;
              ackc_nxt     = '0;
            end
          endcase

          // Every command except a build or a resend answers at once.
          if (cmd.op != OP_BUILD && !(cmd.op == OP_NEXT && !done_r && rpos_r < rcount_r)) begin
            out_valid_nxt          = 1'b1;
            res_nxt.status         = ST_OK;
            res_nxt.chunk_id       = '0;
            res_nxt.is_resend      = 1'b0;
            res_nxt.is_last_chunk  = 1'b0;
            res_nxt.all_done       = done_nxt;
            res_nxt.resend_pending = rcount_nxt - rpos_nxt;
            res_nxt.sent_total     = sent_nxt;
            res_nxt.ack_total      = ackc_nxt;
            if (cmd.op == OP_ACK_WORD) begin
              res_nxt.status = cmd.ack_status;
            end else if (cmd.op == OP_NEXT) begin
              if (!done_r && next_new_r < eff_total) begin
                res_nxt.chunk_id      = next_new_r[CHUNK_W-1:0];
                res_nxt.is_last_chunk = last_of(next_new_r[CHUNK_W-1:0], chunk_total);
              end else begin
                res_nxt.status = ST_NOTHING;
              end
            end
          end
        end
      end
      BK_RESEND_RD: begin
        out_valid_nxt          = 1'b1;
        res_nxt.status         = ST_OK;
        res_nxt.chunk_id       = ram_rdata;
        res_nxt.is_resend      = 1'b1;
        res_nxt.is_last_chunk  = last_of(ram_rdata, chunk_total);
        res_nxt.all_done       = done_r;
        res_nxt.resend_pending = rcount_r - rpos_r;
        res_nxt.sent_total     = sent_r;
        res_nxt.ack_total      = ackc_r;
      end
      BK_SCAN_LOAD: begin
        if (wc_r == nwords_r) begin
          out_valid_nxt          = 1'b1;
          res_nxt.status         = ST_OK;
          res_nxt.chunk_id       = '0;
          res_nxt.is_resend      = 1'b0;
          res_nxt.is_last_chunk  = 1'b0;
          res_nxt.all_done       = done_r;
          res_nxt.resend_pending = rcount_r - rpos_r;
          res_nxt.sent_total     = sent_r;
          res_nxt.ack_total      = ackc_r;
        end else begin
          mask_nxt  = ~acked_r[wc_r[WIDX_W-1:0]] & lim_mask;
          mbase_nxt = wc_r[WIDX_W-1:0];
          wc_nxt    = wc_r + NWC_W'(1);
        end
      end
      BK_SCAN_PICK: begin
        if (mask_r != '0) begin
          ram_we     = 1'b1;
          rcount_nxt = rcount_r + CNT_W'(1);
          mask_nxt   = mask_r & (mask_r - WORD_BITS'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      acked_r     <= '{default: '0};
      shadow_r    <= '{default: '0};
      rcount_r    <= '0;
      rpos_r      <= '0;
      next_new_r  <= '0;
      done_r      <= 1'b0;
      sent_r      <= '0;
      ackc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acked_r     <= acked_nxt;
      shadow_r    <= shadow_nxt;
      rcount_r    <= rcount_nxt;
      rpos_r      <= rpos_nxt;
      next_new_r  <= next_new_nxt;
      done_r      <= done_nxt;
      sent_r      <= sent_nxt;
      ackc_r      <= ackc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wc_r     <= wc_nxt;
    nwords_r <= nwords_nxt;
    limit_r  <= limit_nxt;
    mask_r   <= mask_nxt;
    mbase_r  <= mbase_nxt;
    res_r    <= res_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/srcs_checker.sv
// Port-level assertions for the chunk scheduler, bound to its top level.
`default_nettype none

module srcs_checker import srcs_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [OUT_USER_W-1:0] out_tuser,
  input wire logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Only a successful issue carries a chunk, a resend mark or a last-chunk mark.
  a_no_chunk_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != ST_OK) |->
      (out_tdata[CHUNK_W-1:0] == '0) && !out_tuser[2] && !out_tlast)
    else $error("chunk fields set on a non-ok result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind selective_repeat_chunk_scheduler srcs_checker u_srcs_checker (.*);

`default_nettype wire

FILE: dv/selective_repeat_chunk_scheduler_checker.sv
// Checker for the chunk scheduler: watches all ports, predicts each result and compares it.
`timescale 1ns / 100ps

module selective_repeat_chunk_scheduler_checker import srcs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  // word_index, bitmap_word, ack_image, ack_chunk_total, rcv_count, ack_complete
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic                  in_tlast,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  // chunk_id, all_done, resend_pending, sent_total, ack_total
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  // status, is_resend
  input  wire logic [OUT_USER_W-1:0] out_tuser,
  input  wire logic                  out_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  check_end,
  output int                         fail_count,
  output int                         results_owed
);

  typedef struct packed {
    status_t            status;
    logic [CHUNK_W-1:0] chunk;
    logic               resend;
    logic               last_chunk;
    logic               done;
    logic [CNT_W-1:0]   pending;
    logic [CTR_W-1:0]   sent;
    logic [CTR_W-1:0]   acks;
  } sched_result_t;

  logic [IMG_W-1:0]     image_reg;
  logic [TOT_W-1:0]     total_reg;
  logic [WORD_BITS-1:0] sent_bits  [NWORDS];
  logic [WORD_BITS-1:0] acked_bits [NWORDS];
  logic [WORD_BITS-1:0] ack_shadow [NWORDS];
  logic [CHUNK_W-1:0]   retry_list [MAX_CHUNKS];
  int                   retry_count;
  int                   retry_pos;
  int                   next_fresh;
  logic                 transfer_done;
  logic [CTR_W-1:0]     issued_ctr;
  logic [CTR_W-1:0]     commit_ctr;

  sched_result_t results_due [$];
  sched_result_t due_res;
  sched_result_t seen_res;
  bit            end_checked;

  initial begin
    fail_count   = 0;
    results_owed = 0;
    end_checked  = 1'b0;
  end

  task automatic log_failure(input string msg);
    $display("[%0t] CHECK: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_schedule();
    foreach (sent_bits[w]) begin
      sent_bits[w]  = '0;
      acked_bits[w] = '0;
      ack_shadow[w] = '0;
    end
    retry_count   = 0;
    retry_pos     = 0;
    next_fresh    = 0;
    transfer_done = 1'b0;
    issued_ctr    = '0;
    commit_ctr    = '0;
  endtask

  // Scans and new chunks never go past the map, whatever the register says.
  function automatic int fresh_limit();
    return (total_reg > MAX_CHUNKS) ? MAX_CHUNKS : int'(total_reg);
  endfunction

  task automatic predict_schedule(input op_t op, input logic [WIDX_W-1:0] widx,
                                  input logic [WORD_BITS-1:0] word, input logic last,
                                  input logic [IMG_W-1:0] a_img, input logic [TOT_W-1:0] a_tot,
                                  input logic [TOT_W-1:0] a_rcv, input logic a_cmp,
                                  output sched_result_t r);
    int  limit;
    bit  issued;
    r      = '0;
    r.status = ST_OK;
    limit  = fresh_limit();
    issued = 1'b0;
    case (op)
      OP_ACK_WORD: begin
        ack_shadow[widx] = word;
        if (last) begin
          if (a_img != image_reg) begin
            r.status = ST_WRONG_IMAGE;
          end else if (a_tot != total_reg) begin
            r.status = ST_COUNT_MISMATCH;
          end else begin
            acked_bits = ack_shadow;
            commit_ctr = commit_ctr + 1'b1;
            if (a_cmp || a_rcv == total_reg) transfer_done = 1'b1;
          end
          foreach (ack_shadow[w]) ack_shadow[w] = '0;
        end
      end
      OP_BUILD: begin
        retry_count = 0;
        retry_pos   = 0;
        for (int i = 0; i < limit; i++) begin
          if (sent_bits[i / WORD_BITS][i % WORD_BITS] &&
              !acked_bits[i / WORD_BITS][i % WORD_BITS]) begin
            retry_list[retry_count] = CHUNK_W'(i);
            retry_count++;
          end
        end
      end
      OP_NEXT: begin
        if (!transfer_done) begin
          if (retry_pos < retry_count && retry_pos < MAX_CHUNKS) begin
            r.chunk  = retry_list[retry_pos];
            r.resend = 1'b1;
            retry_pos++;
            issued   = 1'b1;
          end else if (next_fresh < limit) begin
            r.chunk = CHUNK_W'(next_fresh);
            sent_bits[next_fresh / WORD_BITS][next_fresh % WORD_BITS] = 1'b1;
            next_fresh++;
            issued  = 1'b1;
          end
        end
        if (issued) begin
          r.last_chunk = (total_reg != 0) && ({1'b0, r.chunk} == total_reg - 1'b1);
          issued_ctr   = issued_ctr + 1'b1;
        end else begin
          r.status = ST_NOTHING;
        end
      end
      default: clear_schedule();
    endcase
    r.done    = transfer_done;
    r.pending = (retry_count >= retry_pos) ? CNT_W'(retry_count - retry_pos) : '0;
    r.sent    = issued_ctr;
    r.acks    = commit_ctr;
  endtask

  task automatic compare_field(input string name, input longint unsigned got,
                               input longint unsigned want);
    if (got != want)
      log_failure($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      image_reg = '0;
      total_reg = TOT_W'(1);
      clear_schedule();
      results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IMAGE_NUMBER) image_reg = cfg_wdata;
        else if (cfg_index == CFG_CHUNK_TOTAL) total_reg = cfg_wdata[TOT_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        seen_res.status     = status_t'(out_tuser[1:0]);
        seen_res.resend     = out_tuser[2];
        seen_res.last_chunk = out_tlast;
        seen_res.chunk      = out_tdata[9:0];
        seen_res.done       = out_tdata[10];
        seen_res.pending    = out_tdata[21:11];
        seen_res.sent       = out_tdata[37:22];
        seen_res.acks       = out_tdata[53:38];
        if (results_due.size() == 0) begin
          log_failure("result transaction arrived with nothing outstanding");
        end else begin
          due_res = results_due.pop_front();
          compare_field("status", seen_res.status, due_res.status);
          compare_field("chunk_id", seen_res.chunk, due_res.chunk);
          compare_field("is_resend", seen_res.resend, due_res.resend);
          compare_field("is_last_chunk", seen_res.last_chunk, due_res.last_chunk);
          compare_field("all_done", seen_res.done, due_res.done);
          compare_field("resend_pending", seen_res.pending, due_res.pending);
          compare_field("sent_total", seen_res.sent, due_res.sent);
          compare_field("ack_total", seen_res.acks, due_res.acks);
        end
      end
      if (in_tvalid && in_tready) begin
        predict_schedule(op_t'(in_tuser[1:0]), in_tdata[4:0], in_tdata[36:5], in_tlast,
                         in_tdata[68:37], in_tdata[79:69], in_tdata[90:80], in_tdata[91],
                         due_res);
        results_due.push_back(due_res);
      end
      if (check_end && !end_checked) begin
        end_checked = 1'b1;
        if (results_due.size() != 0)
          log_failure($sformatf("%0d results never arrived", results_due.size()));
      end
    end
    results_owed = results_due.size();
  end

endmodule

FILE: dv/selective_repeat_chunk_scheduler_tb.sv
// Testbench top for the chunk scheduler: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module selective_repeat_chunk_scheduler_tb;
  import srcs_pkg::*;

  // Enough input transactions for a thorough random run.
  localparam int ITEM_TARGET   = 1150;
  // A full-size rebuild is the back end's longest busy stretch, and the
  // receiver stalls and sender gaps are short, so this bound sits many
  // times above the longest quiet stretch of a good run.
  localparam int IDLE_LIMIT    = 20000;
  // Every transaction gives exactly one result, so only a short settle is
  // needed once the last one has come back.
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_THROTTLE
  } rx_mode_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [IN_USER_W-1:0]  in_tuser  = '0;
  logic                  in_tlast  = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  check_end = 1'b0;

  int fail_count;
  int results_owed;
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  rx_mode_t rx_mode     = RX_STREAM;
  int       rx_left     = 0;
  int       rx_phase    = 0;

  selective_repeat_chunk_scheduler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  selective_repeat_chunk_scheduler_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .check_end    (check_end),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver switches between streaming, coin-toss acceptance and a
  // regular throttle that is ready only while rx_phase is below 2. Each mode
  // lasts a random stretch, so stalls land on every stage of the block's work.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    rx_phase = (rx_phase + 1) % 7;
    case (rx_mode)
      RX_STREAM: out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      default:   out_tready <= (rx_phase < 2);
    endcase
  end

  // The watchdog restarts on any transaction or register write; a long quiet
  // stretch means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one input transaction and returns at the falling edge after it
  // has been taken. The sender works in bursts; at the end of a burst it may
  // drop valid for a random gap before the next one starts. Valid is only ever
  // lowered and raised on different falling edges.
  task automatic push_cmd(input op_t op, input logic [WIDX_W-1:0] widx,
                          input logic [WORD_BITS-1:0] word, input logic last,
                          input logic [IMG_W-1:0] img, input logic [TOT_W-1:0] tot,
                          input logic [TOT_W-1:0] rcv, input logic cmp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {4'b0, cmp, rcv, tot, img, word, widx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // BUILD, NEXT and RESTART ignore everything but the operation, so the other
  // fields carry random junk to show that it really is ignored.
  task automatic push_simple(input op_t op);
    push_cmd(op, WIDX_W'($urandom), $urandom, 1'($urandom), $urandom,
             TOT_W'($urandom), TOT_W'($urandom), 1'($urandom));
  endtask

  // Now and then a completely random transaction, full field ranges included.
  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0)
      push_cmd(op_t'($urandom_range(0, 3)), WIDX_W'($urandom), $urandom, 1'($urandom),
               $urandom, TOT_W'($urandom), TOT_W'($urandom), 1'($urandom));
  endtask

  // Holds the sender back until every outstanding result has come home, then
  // lets the block settle. Register writes only ever follow this.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Both registers are written on consecutive edges with the enable held high.
  task automatic write_config(input logic [IMG_W-1:0] image, input logic [TOT_W-1:0] total);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_NUMBER;
    cfg_wdata <= image;
    @(negedge clk);
    cfg_index <= CFG_CHUNK_TOTAL;
    cfg_wdata <= CFG_DATA_W'(total);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int usable_chunks(input logic [TOT_W-1:0] total);
    return (total > MAX_CHUNKS) ? MAX_CHUNKS : int'(total);
  endfunction

  // Sends one acknowledgement: the bitmap words in ascending order, a few of
  // them skipped, with the header on the last word. Most headers match the
  // current image and chunk total so that the map is committed; the rest are rejected.
  task automatic send_ack_map(input logic [IMG_W-1:0] image, input logic [TOT_W-1:0] total);
    int                   chunks;
    int                   n_words;
    logic [WORD_BITS-1:0] word;
    logic [IMG_W-1:0]     img;
    logic [TOT_W-1:0]     tot;
    logic [TOT_W-1:0]     rcv;
    logic                 cmp;
    chunks  = usable_chunks(total);
    n_words = (chunks + WORD_BITS - 1) / WORD_BITS;
    if (n_words == 0) n_words = 1;
    for (int w = 0; w < n_words; w++) begin
      // Mostly ones, so that most sent chunks count as received.
      word = ($urandom_range(0, 5) == 0) ? $urandom : ($urandom | $urandom);
      if (w != n_words - 1) begin
        if ($urandom_range(0, 7) != 0)
          push_cmd(OP_ACK_WORD, WIDX_W'(w), word, 1'b0, $urandom, TOT_W'($urandom),
                   TOT_W'($urandom), 1'($urandom));
      end else begin
        img = ($urandom_range(0, 9) == 0) ? $urandom : image;
        tot = ($urandom_range(0, 9) == 0) ? TOT_W'($urandom) : total;
        rcv = ($urandom_range(0, 9) == 0) ? total
                                          : TOT_W'($urandom_range(0, (chunks > 0) ? chunks - 1 : 0));
        cmp = ($urandom_range(0, 11) == 0);
        push_cmd(OP_ACK_WORD, WIDX_W'(w), word, 1'b1, img, tot, rcv, cmp);
      end
    end
  endtask

  // One transfer: configure, optionally restart, then several rounds of new
  // chunks, an acknowledgement, a rebuild of the resend list and resends.
  // Without a restart the previous transfer carries on under the new settings.
  task automatic run_transfer(input logic [IMG_W-1:0] image, input logic [TOT_W-1:0] total,
                              input bit restart);
    int chunks;
    int rounds;
    int n_new;
    chunks = usable_chunks(total);
    write_config(image, total);
    if (restart) push_simple(OP_RESTART);
    rounds = $urandom_range(2, 5);
    repeat (rounds) begin
      n_new = $urandom_range(1, (chunks + 2 < 40) ? chunks + 2 : 40);
      repeat (n_new) begin
        maybe_noise();
        push_simple(OP_NEXT);
      end
      send_ack_map(image, total);
      push_simple(OP_BUILD);
      repeat ($urandom_range(1, 12)) begin
        maybe_noise();
        push_simple(OP_NEXT);
      end
      // Occasionally the sender stops mid-transfer until the block is empty.
      if ($urandom_range(0, 4) == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    logic [IMG_W-1:0] image;
    logic [TOT_W-1:0] total;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, starting from the reset settings of image 0 and one chunk.
    // The single chunk goes out new and is the last chunk, after which there
    // is nothing left to send.
    push_simple(OP_NEXT);
    push_simple(OP_NEXT);
    // It was never acknowledged, so the rebuild lists it and NEXT resends it.
    push_simple(OP_BUILD);
    push_simple(OP_NEXT);
    // A plain bitmap word at the top of the map, header fields at their
    // extremes but unused since it is not the final word.
    push_cmd(OP_ACK_WORD, 5'd31, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 11'h7FF, 11'h7FF, 1'b1);
    // Final words rejected for the wrong image and then for the wrong count.
    push_cmd(OP_ACK_WORD, 5'd0, 32'h0000_0001, 1'b1, 32'd1, 11'd1, 11'd1, 1'b1);
    push_cmd(OP_ACK_WORD, 5'd0, 32'h0000_0001, 1'b1, 32'd0, 11'd1024, 11'd1, 1'b1);
    // A committed acknowledgement that receives nothing; the chunk stays due.
    push_cmd(OP_ACK_WORD, 5'd0, 32'h0000_0000, 1'b1, 32'd0, 11'd1, 11'd0, 1'b0);
    push_simple(OP_BUILD);
    // Received count equal to the total finishes the transfer, after which
    // NEXT has nothing to offer.
    push_cmd(OP_ACK_WORD, 5'd0, 32'h0000_0001, 1'b1, 32'd0, 11'd1, 11'd1, 1'b0);
    push_simple(OP_NEXT);
    push_simple(OP_RESTART);
    wait_idle();

    // A chunk total of zero never issues anything; the complete flag alone
    // finishes the transfer.
    write_config(32'hFFFF_FFFF, 11'd0);
    push_simple(OP_NEXT);
    push_simple(OP_BUILD);
    push_cmd(OP_ACK_WORD, 5'd0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 11'd0, 11'd5, 1'b1);
    push_simple(OP_NEXT);
    wait_idle();

    // A chunk total beyond the map: scans stop at the map size, while the
    // header check still compares against the full register value.
    write_config(32'd5, 11'h7FF);
    push_simple(OP_RESTART);
    push_simple(OP_NEXT);
    push_simple(OP_NEXT);
    push_simple(OP_BUILD);
    push_simple(OP_NEXT);
    push_cmd(OP_ACK_WORD, 5'd0, 32'h0000_0003, 1'b1, 32'd5, 11'h7FF, 11'd2, 1'b0);
    push_simple(OP_BUILD);
    push_simple(OP_NEXT);
    wait_idle();

    // Random transfers. Most use small chunk totals; a few go to the full map,
    // past it or to zero, and some skip the restart.
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0:       image = 32'd0;
        1:       image = 32'hFFFF_FFFF;
        default: image = $urandom;
      endcase
      case ($urandom_range(0, 15))
        0:       total = 11'd1024;
        1:       total = 11'd1;
        2:       total = TOT_W'($urandom_range(31, 33));
        3:       total = TOT_W'($urandom_range(1, 1024));
        4:       total = ($urandom_range(0, 3) == 0) ? 11'd0 : TOT_W'($urandom_range(1025, 2047));
        default: total = TOT_W'($urandom_range(1, 80));
      endcase
      run_transfer(image, total, $urandom_range(0, 3) != 0);
    end

    check_end <= 1'b1;
    repeat (3) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: selective_repeat_chunk_scheduler.f
rtl/srcs_pkg.sv
rtl/srcs_ram.sv
rtl/srcs_front.sv
rtl/srcs_back.sv
rtl/selective_repeat_chunk_scheduler.sv
rtl/srcs_checker.sv
dv/selective_repeat_chunk_scheduler_checker.sv
dv/selective_repeat_chunk_scheduler_tb.sv
